/* design/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define KSC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset
`define KSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* design/kscp_pkg.sv */
`timescale 1ns / 1ps

package kscp_pkg;

  localparam int unsigned LETTERS = 26;
  localparam int unsigned IDX_W   = 5;

  // Request action codes
  localparam logic [2:0] ACT_CLEAR   = 3'd0;
  localparam logic [2:0] ACT_KEY     = 3'd1;
  localparam logic [2:0] ACT_FINISH  = 3'd2;
  localparam logic [2:0] ACT_ENCRYPT = 3'd3;
  localparam logic [2:0] ACT_DECRYPT = 3'd4;

  // ASCII bounds
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] char_in;
  } req_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       table_ready;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_RESULT
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic clear;
    logic key_add;
    logic fill_start;
    logic fill_step;
    logic lookup;
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic done;
    logic walk_last;
    logic fill_full;
  } status_t;

  function automatic logic is_letter(logic [7:0] c);
    return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
           ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z));
  endfunction

  // Case-folded letter index, zero for non-letters
  function automatic logic [IDX_W-1:0] letter_idx(logic [7:0] c);
    logic [7:0] diff;
    diff = 8'd0;
    if ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) begin
      diff = c - CH_UPPER_A;
    end else if ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) begin
      diff = c - CH_LOWER_A;
    end
    return diff[IDX_W-1:0];
  endfunction

endpackage

/* design/kscp_datapath.sv */
`timescale 1ns / 1ps

module kscp_datapath import kscp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  req_t    req,
  input  cmd_t    cmd,
  output status_t status,
  output rsp_t    rsp
);

  logic [IDX_W-1:0]   cipher_mem  [LETTERS];
  logic [IDX_W-1:0]   inverse_mem [LETTERS];

  logic [LETTERS-1:0] letters_used;
  logic [IDX_W-1:0]   fill_count;
  logic [IDX_W-1:0]   walk_idx;
  logic               alphabet_done;

  logic [IDX_W-1:0]   add_letter;
  logic               add_req;
  logic               add_en;
  logic [IDX_W-1:0]   req_idx;

  logic [7:0]         cap_char;
  logic               cap_letter;
  logic               cap_done;
  logic [IDX_W-1:0]   rd_data;

  assign req_idx = letter_idx(req.char_in);

  // Letter insertion: key load or finish walk share one write port
  always_comb begin
    add_letter = cmd.fill_step ? walk_idx : req_idx;
    add_req    = cmd.fill_step ||
                 (cmd.key_add && !alphabet_done && is_letter(req.char_in));
    add_en     = add_req && !letters_used[add_letter] &&
                 (fill_count < IDX_W'(LETTERS));
  end

  // Both tables written together: inverse[letter] = position
  always_ff @(posedge clk) begin
    if (add_en) begin
      cipher_mem[fill_count]  <= add_letter;
      inverse_mem[add_letter] <= fill_count;
    end
  end

  // Key state
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      letters_used  <= '0;
      fill_count    <= '0;
      alphabet_done <= 1'b0;
      walk_idx      <= '0;
    end else begin
      if (add_en) begin
        letters_used[add_letter] <= 1'b1;
        fill_count               <= fill_count + 1'b1;
      end
      if (cmd.fill_start) begin
        walk_idx <= '0;
      end else if (cmd.fill_step) begin
        walk_idx <= walk_idx + 1'b1;
        if (status.walk_last) begin
          alphabet_done <= 1'b1;
        end
      end
    end
  end

  // Lookup: registered table read plus captured request
  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      cap_char   <= req.char_in;
      cap_letter <= is_letter(req.char_in);
      cap_done   <= alphabet_done;
      rd_data    <= (req.action == ACT_DECRYPT) ? inverse_mem[req_idx]
                                                : cipher_mem[req_idx];
    end
  end

  // Result formatting
  always_comb begin
    rsp.table_ready = cap_done;
    if (cap_done && cap_letter) begin
      rsp.char_out = CH_UPPER_A + {3'b000, rd_data};
    end else begin
      rsp.char_out = cap_char;
    end
  end

  assign status.done      = alphabet_done;
  assign status.walk_last = (walk_idx == IDX_W'(LETTERS - 1));
  assign status.fill_full = (fill_count == IDX_W'(LETTERS));

endmodule

/* design/kscp_ctrl.sv */
`timescale 1ns / 1ps

module kscp_ctrl import kscp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic [2:0] req_action,
  output logic       req_stall,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  input  status_t    status,
  output cmd_t       cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          case (req_action)
            ACT_CLEAR: begin
              cmd.clear = 1'b1;
            end
            ACT_KEY: begin
              cmd.key_add = 1'b1;
            end
            ACT_FINISH: begin
              if (!status.done) begin
                cmd.fill_start = 1'b1;
                state_next     = ST_FILL;
              end
            end
            ACT_ENCRYPT, ACT_DECRYPT: begin
              cmd.lookup = 1'b1;
              state_next = ST_RESULT;
            end
            default: begin
            end
          endcase
        end
      end
      ST_FILL: begin
        cmd.fill_step = 1'b1;
        if (status.walk_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_RESULT: begin
        if (!rsp_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign req_stall = (state != ST_IDLE);
  assign rsp_valid = (state == ST_RESULT);

endmodule

/* design/keyword_substitution_cipher.sv */
// An encrypt or decrypt request shows its result in the cycle after acceptance.
// A new character is accepted only after the previous result is taken: one table read, then the output state.
// Clear and key requests are handled in the idle state; finish starts a walk over all 26 letters.
// Reset (rst, synchronous, active high) clears the key state; tables hold junk until written.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module keyword_substitution_cipher import kscp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  cmd_t    cmd;
  status_t status;

  kscp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_action (req.action),
    .req_stall  (req_stall),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .status     (status),
    .cmd        (cmd)
  );

  kscp_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .cmd    (cmd),
    .status (status),
    .rsp    (rsp)
  );

  // A finished alphabet always holds all 26 letters
  `KSC_ASSERT_NOW(a_done_full, clk, rst, status.done, status.fill_full)
  // Last walk step completes the alphabet
  `KSC_ASSERT_NEXT(a_walk_done, clk, rst, cmd.fill_step && status.walk_last, status.done)
  // The walk never runs over a finished alphabet
  `KSC_ASSERT_NOW(a_walk_open, clk, rst, cmd.fill_step, !status.done)
  // A transformed result implies the alphabet is finished
  `KSC_ASSERT_NOW(a_ready_done, clk, rst, rsp_valid && rsp.table_ready, status.done)

endmodule
